@@ rtl/bsfv_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfv_pkg
// Types, codes and sizes shared by the byte stream frame validator.
// ----------------------------------------------------------------------------
package bsfv_pkg;

    localparam int MAGIC_LEN = 4;
    localparam int NONCE_LEN = 12;
    localparam int TAG_LEN   = 16;

    localparam int BIF_W = 5;
    localparam logic [31:0] MIN_FRAME_SIZE = 32'(MAGIC_LEN + 1 + 28 + NONCE_LEN + 4 + TAG_LEN);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC   = 2'd0,
        CFG_VERSION = 2'd1,
        CFG_MAX_CT  = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'd0,
        PH_VERSION = 4'd1,
        PH_READER  = 4'd2,
        PH_DOOR    = 4'd3,
        PH_TS      = 4'd4,
        PH_SEQ     = 4'd5,
        PH_KEYVER  = 4'd6,
        PH_NONCE   = 4'd7,
        PH_CTLEN   = 4'd8,
        PH_CT      = 4'd9,
        PH_TAG     = 4'd10,
        PH_TRAIL   = 4'd11
    } phase_t;

    typedef enum logic [3:0] {
        FK_NONE   = 4'd0,
        FK_READER = 4'd1,
        FK_DOOR   = 4'd2,
        FK_TS     = 4'd3,
        FK_SEQ    = 4'd4,
        FK_KEYVER = 4'd5,
        FK_NONCE  = 4'd6,
        FK_CT     = 4'd7,
        FK_TAG    = 4'd8
    } field_kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SMALL   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_OVER_LIMIT  = 3'd4,
        ST_MISMATCH    = 3'd5,
        ST_TRAILING    = 3'd6
    } status_t;

    typedef struct packed {
        field_kind_t kind;
        logic [63:0] value;
        logic        frame_end;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } queue_head_t;

    function automatic field_kind_t word_kind(input phase_t ph);
        field_kind_t k;
        case (ph)
            PH_READER: k = FK_READER;
            PH_DOOR:   k = FK_DOOR;
            PH_TS:     k = FK_TS;
            PH_SEQ:    k = FK_SEQ;
            PH_KEYVER: k = FK_KEYVER;
            default:   k = FK_NONE;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/bsfv_parser.sv @@
// ----------------------------------------------------------------------------
// bsfv_parser
// Front end: takes frame bytes, runs the phase machine and produces results.
// ----------------------------------------------------------------------------
module bsfv_parser
    import bsfv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 push,
    output result_t              push_data
);

    logic [63:0] magic_reg;
    logic [7:0]  version_reg;
    logic [31:0] max_ct_reg;

    phase_t          phase_reg, phase_next;
    logic [BIF_W-1:0] bif_reg, bif_next;
    logic [63:0]     acc_reg, acc_next;
    logic [31:0]     ct_reg, ct_next;
    logic [31:0]     total_reg, total_next;
    status_t         err_reg, err_next;

    logic            accept;
    logic [BIF_W-1:0] bif_inc;
    logic [63:0]     acc_ins;
    logic [7:0]      magic_byte;
    logic [31:0]     ct_dec;
    logic [BIF_W-1:0] word_len;
    field_kind_t     kind;
    logic [63:0]     val;
    status_t         status;

    assign accept     = in_valid && in_ready;
    assign bif_inc    = bif_reg + BIF_W'(1);
    assign acc_ins    = acc_reg | ({56'd0, data_byte} << {bif_reg[2:0], 3'b000});
    assign magic_byte = 8'(magic_reg >> {bif_reg[2:0], 3'b000});
    assign ct_dec     = (ct_reg != 32'd0) ? (ct_reg - 32'd1) : ct_reg;
    assign word_len   = (phase_reg == PH_TS || phase_reg == PH_SEQ) ? BIF_W'(8) : BIF_W'(4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= 64'd0;
            version_reg <= 8'd1;
            max_ct_reg  <= 32'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAGIC:   magic_reg   <= cfg_data;
                CFG_VERSION: version_reg <= cfg_data[7:0];
                CFG_MAX_CT:  max_ct_reg  <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            bif_reg   <= '0;
            acc_reg   <= 64'd0;
            ct_reg    <= 32'd0;
            total_reg <= 32'd0;
            err_reg   <= ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            bif_reg   <= bif_next;
            acc_reg   <= acc_next;
            ct_reg    <= ct_next;
            total_reg <= total_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        bif_next   = bif_reg;
        acc_next   = acc_reg;
        ct_next    = ct_reg;
        total_next = total_reg;
        err_next   = err_reg;
        kind       = FK_NONE;
        val        = 64'd0;
        status     = ST_OK;
        push       = 1'b0;

        if (accept)
        begin
            if (total_reg != 32'hFFFF_FFFF)
            begin
                total_next = total_reg + 32'd1;
            end

            if (err_reg == ST_OK)
            begin
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (data_byte != magic_byte)
                        begin
                            err_next = ST_BAD_MAGIC;
                        end
                        bif_next = bif_inc;
                        if (bif_inc >= BIF_W'(MAGIC_LEN))
                        begin
                            bif_next   = '0;
                            phase_next = PH_VERSION;
                        end
                    end
                    PH_VERSION:
                    begin
                        if (data_byte != version_reg)
                        begin
                            err_next = ST_BAD_VERSION;
                        end
                        phase_next = PH_READER;
                    end
                    PH_READER, PH_DOOR, PH_TS, PH_SEQ, PH_KEYVER:
                    begin
                        acc_next = acc_ins;
                        bif_next = bif_inc;
                        if (bif_inc >= word_len)
                        begin
                            bif_next   = '0;
                            kind       = word_kind(phase_reg);
                            val        = acc_ins;
                            acc_next   = 64'd0;
                            phase_next = phase_t'(phase_reg + 4'd1);
                        end
                    end
                    PH_NONCE:
                    begin
                        kind     = FK_NONCE;
                        val      = {56'd0, data_byte};
                        bif_next = bif_inc;
                        if (bif_inc >= BIF_W'(NONCE_LEN))
                        begin
                            bif_next   = '0;
                            phase_next = PH_CTLEN;
                        end
                    end
                    PH_CTLEN:
                    begin
                        acc_next = acc_ins;
                        bif_next = bif_inc;
                        if (bif_inc >= BIF_W'(4))
                        begin
                            bif_next = '0;
                            acc_next = 64'd0;
                            if (acc_ins > {32'd0, max_ct_reg})
                            begin
                                err_next = ST_OVER_LIMIT;
                            end
                            else
                            begin
                                ct_next    = acc_ins[31:0];
                                phase_next = (acc_ins[31:0] != 32'd0) ? PH_CT : PH_TAG;
                            end
                        end
                    end
                    PH_CT:
                    begin
                        kind    = FK_CT;
                        val     = {56'd0, data_byte};
                        ct_next = ct_dec;
                        if (ct_dec == 32'd0)
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                    PH_TAG:
                    begin
                        kind     = FK_TAG;
                        val      = {56'd0, data_byte};
                        bif_next = bif_inc;
                        if (bif_inc >= BIF_W'(TAG_LEN))
                        begin
                            bif_next   = '0;
                            phase_next = PH_TRAIL;
                        end
                    end
                    default:
                    begin
                        err_next = ST_TRAILING;
                    end
                endcase
            end

            if (last_byte)
            begin
                if (total_next < MIN_FRAME_SIZE)
                begin
                    status = ST_TOO_SMALL;
                end
                else if (err_next != ST_OK)
                begin
                    status = err_next;
                end
                else if (phase_next != PH_TRAIL)
                begin
                    status = ST_MISMATCH;
                end
                phase_next = PH_MAGIC;
                bif_next   = '0;
                acc_next   = 64'd0;
                ct_next    = 32'd0;
                total_next = 32'd0;
                err_next   = ST_OK;
            end

            push = last_byte || (kind != FK_NONE);
        end

        push_data.kind      = kind;
        push_data.value     = val;
        push_data.frame_end = last_byte;
        push_data.status    = status;
    end

endmodule

@@ rtl/bsfv_queue.sv @@
// ----------------------------------------------------------------------------
// bsfv_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module bsfv_queue
    import bsfv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     push_data,
    output logic        not_full,
    input  logic        pop,
    output queue_head_t head
);

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 do_pop;

    assign not_full   = count_reg != FIFO_CW'(FIFO_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.data  = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + FIFO_AW'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + FIFO_AW'(1)) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/bsfv_out.sv @@
// ----------------------------------------------------------------------------
// bsfv_out
// Back end: output register that drives the master stream.
// ----------------------------------------------------------------------------
module bsfv_out
    import bsfv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic [3:0]  m_tuser,
    output logic        m_tlast
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign pop = head.valid && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head.data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, data_reg.status, data_reg.value};
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.frame_end;

endmodule

@@ rtl/byte_stream_frame_validator.sv @@
// ----------------------------------------------------------------------------
// byte_stream_frame_validator
// Checks a framed byte stream and emits header words and payload bytes.
// ----------------------------------------------------------------------------
// path: each result is written from the parser into the result queue and from the
// queue into the output register, which offers it on the master side
// throughput: one byte per cycle; the four-entry result queue drops s_tready
// only when it is full because the master side is stalled
// reset: frame state cleared, registers at magic 0, version 1, limit 4096
module byte_stream_frame_validator
    import bsfv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte
    input  logic                 s_tlast,   // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // field_value[63:0], status[66:64], zero
    output logic [3:0]           m_tuser,   // field_kind
    output logic                 m_tlast    // frame_end
);

    logic        push;
    result_t     push_data;
    logic        pop;
    queue_head_t head;

    bsfv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .push      (push),
        .push_data (push_data)
    );

    bsfv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .not_full  (s_tready),
        .pop       (pop),
        .head      (head)
    );

    bsfv_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/bsfv_checker.sv @@
// ----------------------------------------------------------------------------
// bsfv_port_checks
// Port level checks on the frame validator, bound to the top level.
// ----------------------------------------------------------------------------
module bsfv_port_checks
    import bsfv_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [71:0]          m_tdata,
    input logic [3:0]           m_tuser,
    input logic                 m_tlast
);

    // stalled transaction stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transaction dropped while stalled");

    // status only on frame end
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[66:64] == ST_OK)
        else $error("status set without frame end");

    // empty kind only on frame end, with zero value
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == FK_NONE |-> m_tlast && m_tdata[63:0] == 64'd0)
        else $error("empty result that is not a frame end");

    // single byte kinds carry one byte
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == FK_NONCE || m_tuser == FK_CT || m_tuser == FK_TAG)
        |-> m_tdata[63:8] == 56'd0)
        else $error("byte field wider than a byte");

    // kind and padding in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= FK_TAG && m_tdata[71:67] == 5'd0)
        else $error("field kind or padding out of range");

endmodule

bind byte_stream_frame_validator bsfv_port_checks u_bsfv_port_checks (.*);
